FILE: sv/psv_pkg.sv
// psv_pkg: shared types and constants for the prime sieve block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psv_pkg;

  // Default size of the mark store (number of candidate indices).
  localparam int unsigned SieveSizeDef = 256;

  // Fixed field widths of the transaction payload.
  localparam int unsigned LimitW = 9;
  localparam int unsigned PrimeW = 8;

  // Smallest prime; scanning starts here.
  localparam int unsigned FirstPrime = 2;

  // One result transaction as it travels from sequencer to output stage.
  typedef struct packed {
    logic [PrimeW-1:0] prime_value;
    logic              last;
    logic              empty_res;
  } res_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFill  = 5'b00010,
    StScan  = 5'b00100,
    StCross = 5'b01000,
    StFlush = 5'b10000
  } state_e;

endpackage

FILE: sv/psv_mark_mem.sv
// psv_mark_mem: one-bit candidate mark store, one write and one read port.
// Depends on psv_pkg; read data is registered.
`timescale 1ns / 1ps

module psv_mark_mem
  import psv_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = SieveSizeDef,
  localparam int unsigned AddrW = $clog2(SIEVE_SIZE)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [SIEVE_SIZE];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/psv_out_reg.sv
// psv_out_reg: output register that holds one result transaction.
// Depends on psv_pkg (res_t).
`timescale 1ns / 1ps

module psv_out_reg
  import psv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_vld_i,
  output logic push_rdy_o,
  input  res_t push_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic vld_q;
  res_t data_q;

  assign push_rdy_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_vld_i && push_rdy_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_vld_i && push_rdy_o) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

FILE: sv/psv_ctrl.sv
// psv_ctrl: sieve sequencer; fills, scans and crosses off the mark store.
// Depends on psv_pkg; drives psv_mark_mem ports and pushes into psv_out_reg.
`timescale 1ns / 1ps

module psv_ctrl
  import psv_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = SieveSizeDef,
  localparam int unsigned AddrW = $clog2(SIEVE_SIZE),
  localparam int unsigned CntW  = $clog2(2 * SIEVE_SIZE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LimitW-1:0] limit_i,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic              mem_wdata_o,
  output logic              mem_re_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  logic              mem_rdata_i,
  output logic              push_vld_o,
  input  logic              push_rdy_i,
  output res_t              push_data_o
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   lim_q, lim_d;
  logic [AddrW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   ev_q, ev_d;
  logic              ev_vld_q, ev_vld_d;
  logic [CntW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   step_q, step_d;
  logic [CntW-1:0]   pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic [CntW-1:0]   lim_sat;
  logic              found;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    if (limit_i > LimitW'(SIEVE_SIZE)) begin
      lim_sat = CntW'(SIEVE_SIZE);
    end else if (limit_i < LimitW'(FirstPrime)) begin
      lim_sat = CntW'(FirstPrime);
    end else begin
      lim_sat = CntW'(limit_i);
    end
  end

  assign found = (state_q == StScan) && ev_vld_q && mem_rdata_i;

  always_comb begin
    state_d     = state_q;
    lim_d       = lim_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    ev_d        = ev_q;
    ev_vld_d    = ev_vld_q;
    cur_d       = cur_q;
    step_d      = step_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q;
    mem_wdata_o = 1'b1;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AddrW-1:0];
    push_vld_o  = 1'b0;
    push_data_o = '{prime_value: PrimeW'(pend_q), last: 1'b0, empty_res: 1'b0};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          lim_d      = lim_sat;
          fill_d     = '0;
          pend_vld_d = 1'b0;
          state_d    = StFill;
        end
      end
      StFill: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = fill_q;
        mem_wdata_o = 1'b1;
        fill_d      = fill_q + AddrW'(1);
        if (fill_q == AddrW'(SIEVE_SIZE - 1)) begin
          idx_d    = CntW'(FirstPrime);
          ev_vld_d = 1'b0;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (found) begin
          if (pend_vld_q && !push_rdy_i) begin
            // Hold: retry this index once the output frees up.
            idx_d    = ev_q;
            ev_vld_d = 1'b0;
          end else begin
            push_vld_o = pend_vld_q;
            pend_d     = ev_q;
            pend_vld_d = 1'b1;
            cur_d      = ev_q + ev_q;
            step_d     = ev_q;
            idx_d      = ev_q + CntW'(1);
            ev_vld_d   = 1'b0;
            state_d    = StCross;
          end
        end else if (idx_q < lim_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AddrW-1:0];
          ev_d        = idx_q;
          ev_vld_d    = 1'b1;
          idx_d       = idx_q + CntW'(1);
        end else begin
          ev_vld_d = 1'b0;
          if (!ev_vld_q) begin
            state_d = StFlush;
          end
        end
      end
      StCross: begin
        if (cur_q < lim_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q[AddrW-1:0];
          mem_wdata_o = 1'b0;
          cur_d       = cur_q + step_q;
        end else begin
          state_d = StScan;
        end
      end
      StFlush: begin
        push_vld_o  = 1'b1;
        push_data_o = '{prime_value: pend_vld_q ? PrimeW'(pend_q) : '0,
                        last: 1'b1,
                        empty_res: !pend_vld_q};
        if (push_rdy_i) begin
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      fill_q     <= '0;
    end else begin
      state_q    <= state_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      fill_q     <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_d;
    idx_q  <= idx_d;
    ev_q   <= ev_d;
    cur_q  <= cur_d;
    step_q <= step_d;
    pend_q <= pend_d;
  end

endmodule

FILE: sv/prime_sieve.sv
// prime_sieve: top level of the sieve of Eratosthenes block.
// Depends on psv_pkg, psv_mark_mem, psv_ctrl and psv_out_reg.
`timescale 1ns / 1ps

// Each input transaction carries a limit n; the block returns every prime
// below n in ascending order, one result transaction per prime, with last
// set on the final one. A limit of 2 or less gives a single result with
// empty_res and last set and prime_value zero; a limit above SIEVE_SIZE is
// treated as SIEVE_SIZE. One item is worked at a time: in_stall_o stays high
// from acceptance until the last result has been handed to the output
// register. Each item refills all SIEVE_SIZE entries of the mark memory
// with ones, one entry per cycle through its single write port, then
// scans each index below n, restarts the scan after each prime found,
// and crosses off that prime's multiples. The refill and the
// crossing-off writes, both through the single write port, set most of
// the run time. The output register takes results while the sequencer
// keeps working, so a stalled consumer only delays the block when a
// second result is ready before the first has been taken.
module prime_sieve
  import psv_pkg::*;
#(
  parameter int unsigned SIEVE_SIZE = SieveSizeDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LimitW-1:0] limit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PrimeW-1:0] prime_value_o,
  output logic              last_o,
  output logic              empty_res_o
);

  localparam int unsigned AddrW = $clog2(SIEVE_SIZE);

  // Memory port wires between sequencer and mark store.
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_rdata;

  // Result hand-off into the output register.
  logic push_vld;
  logic push_rdy;
  res_t push_data;
  res_t out_data;

  // Sequencer: fill, scan, cross off, and track the pending prime so the
  // last flag can be attached once the scan is done.
  psv_ctrl #(
    .SIEVE_SIZE(SIEVE_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .limit_i     (limit_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .push_vld_o  (push_vld),
    .push_rdy_i  (push_rdy),
    .push_data_o (push_data)
  );

  // Mark store: one bit per candidate index, registered read data.
  psv_mark_mem #(
    .SIEVE_SIZE(SIEVE_SIZE)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: decouple the consumer from the sequencer.
  psv_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_rdy_o  (push_rdy),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign prime_value_o = out_data.prime_value;
  assign last_o        = out_data.last;
  assign empty_res_o   = out_data.empty_res;

endmodule
